// ===== rtl/mtte_pkg.sv =====
// Shared types, constants and the letter table of the multi-tap text entry unit.
// Used by mtte_ctrl, mtte_dp and multi_tap_text_entry_unit; depends on nothing.
package mtte_pkg;

  localparam int LINE_LENGTH     = 32;
  localparam int KEY_COUNT       = 9;
  localparam int LETTERS_PER_KEY = 3;
  localparam int ADDR_W          = $clog2(LINE_LENGTH);
  localparam int KEY_W           = $clog2(KEY_COUNT);

  localparam logic [8:0] CHORD_CLEAR = 9'h006;
  localparam logic [8:0] CHORD_MODE  = 9'h030;
  localparam logic [8:0] CHORD_BACK  = 9'h0C0;
  localparam logic [8:0] CHORD_SPACE = 9'h180;

  localparam logic [6:0] SPACE_CODE  = 7'h20;
  localparam logic [6:0] DIGIT_ONE   = 7'h31;

  localparam logic [5:0] CURSOR_NONE = 6'h3F;
  localparam logic [5:0] CURSOR_LAST = 6'(LINE_LENGTH - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(LINE_LENGTH - 1);
  localparam logic [1:0] LETTER_LAST = 2'(LETTERS_PER_KEY - 1);

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic write;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_result;
    logic need_sweep;
    logic sweep_last;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [6:0] letter_code(input logic [KEY_W-1:0] k,
                                             input logic [1:0] li);
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
    begin
      c0 = SPACE_CODE;
      c1 = SPACE_CODE;
      c2 = SPACE_CODE;
      case (k)
        4'd0: begin c0 = 7'h2E; c1 = 7'h51; c2 = 7'h5A; end
        4'd1: begin c0 = 7'h41; c1 = 7'h42; c2 = 7'h43; end
        4'd2: begin c0 = 7'h44; c1 = 7'h45; c2 = 7'h46; end
        4'd3: begin c0 = 7'h47; c1 = 7'h48; c2 = 7'h49; end
        4'd4: begin c0 = 7'h4A; c1 = 7'h4B; c2 = 7'h4C; end
        4'd5: begin c0 = 7'h4D; c1 = 7'h4E; c2 = 7'h4F; end
        4'd6: begin c0 = 7'h50; c1 = 7'h52; c2 = 7'h53; end
        4'd7: begin c0 = 7'h54; c1 = 7'h55; c2 = 7'h56; end
        4'd8: begin c0 = 7'h57; c1 = 7'h58; c2 = 7'h59; end
        default: begin c0 = SPACE_CODE; c1 = SPACE_CODE; c2 = SPACE_CODE; end
      endcase
      case (li)
        2'd0:    letter_code = c0;
        2'd1:    letter_code = c1;
        2'd2:    letter_code = c2;
        default: letter_code = SPACE_CODE;
      endcase
    end
  endfunction

endpackage

// ===== rtl/mtte_ctrl.sv =====
// Controller state machine of the multi-tap text entry unit.
// Sequences load, execute, buffer sweep, buffer write and publish; uses mtte_pkg.
module mtte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mtte_pkg::dp_stat_t  stat,
  output mtte_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_SWEEP   = 3'd2;
  localparam logic [2:0] ST_WRITE   = 3'd3;
  localparam logic [2:0] ST_PUBLISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.no_result) begin
          state_nxt = ST_IDLE;
        end else if (stat.need_sweep) begin
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mtte_dp.sv =====
// Datapath of the multi-tap text entry unit: line buffer, cursor, mode, BCD counter
// and result registers. Driven by commands from mtte_ctrl; uses mtte_pkg.
module mtte_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mtte_pkg::ctrl_cmd_t        cmd,
  output mtte_pkg::dp_stat_t         stat,
  input  logic [8:0]                 in_key_mask,
  input  logic                       in_restart,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [15:0]                out_press_count_bcd,
  output logic                       out_number_mode,
  output logic signed [5:0]          out_cursor_pos,
  output logic                       out_buffer_cleared,
  output logic                       out_buffer_shifted,
  output logic                       out_char_written,
  output logic [4:0]                 out_char_pos,
  output logic [6:0]                 out_char_code
);

  localparam int AW = mtte_pkg::ADDR_W;
  localparam int KW = mtte_pkg::KEY_W;

  logic [8:0]    mask_r;
  logic          restart_r;
  logic [5:0]    cursor_r, cursor_nxt;
  logic [1:0]    li_r, li_nxt;
  logic [8:0]    prev_r, prev_nxt;
  logic          mode_r, mode_nxt;
  logic [15:0]   bcd_r, bcd_nxt;
  logic [6:0]    buf_r [mtte_pkg::LINE_LENGTH];
  logic [AW-1:0] sw_cnt_r;
  logic          sw_clear_r, sw_clear_nxt;
  logic          need_sweep;
  logic          res_cleared_r, res_cleared_nxt;
  logic          res_shifted_r, res_shifted_nxt;
  logic          res_written_r, res_written_nxt;
  logic [AW-1:0] res_pos_r, res_pos_nxt;
  logic [6:0]    res_code_r, res_code_nxt;
  logic          out_valid_r;

  always_comb begin
    logic          single;
    logic [KW-1:0] k;
    logic [5:0]    adv_cur;
    logic          adv_shift;
    logic [3:0]    d0, d1, d2, d3;
    cursor_nxt      = cursor_r;
    li_nxt          = li_r;
    prev_nxt        = prev_r;
    mode_nxt        = mode_r;
    bcd_nxt         = bcd_r;
    sw_clear_nxt    = 1'b0;
    need_sweep      = 1'b0;
    res_cleared_nxt = 1'b0;
    res_shifted_nxt = 1'b0;
    res_written_nxt = 1'b0;
    res_pos_nxt     = '0;
    res_code_nxt    = '0;
    single = (mask_r != '0) && ((mask_r & (mask_r - 9'd1)) == '0);
    k = '0;
    for (int i = 0; i < mtte_pkg::KEY_COUNT; i++) begin
      if (mask_r[i]) begin
        k = k | KW'(i);
      end
    end
    adv_shift = (cursor_r == mtte_pkg::CURSOR_LAST);
    adv_cur   = adv_shift ? mtte_pkg::CURSOR_LAST : cursor_r + 6'd1;
    d0 = bcd_r[3:0];
    d1 = bcd_r[7:4];
    d2 = bcd_r[11:8];
    d3 = bcd_r[15:12];
    if (d0 == 4'd9) begin
      d0 = 4'd0;
      if (d1 == 4'd9) begin
        d1 = 4'd0;
        if (d2 == 4'd9) begin
          d2 = 4'd0;
          d3 = (d3 == 4'd9) ? 4'd0 : d3 + 4'd1;
        end else begin
          d2 = d2 + 4'd1;
        end
      end else begin
        d1 = d1 + 4'd1;
      end
    end else begin
      d0 = d0 + 4'd1;
    end
    if (restart_r) begin
      cursor_nxt      = mtte_pkg::CURSOR_NONE;
      li_nxt          = '0;
      prev_nxt        = '0;
      mode_nxt        = 1'b0;
      bcd_nxt         = '0;
      sw_clear_nxt    = 1'b1;
      need_sweep      = 1'b1;
      res_cleared_nxt = 1'b1;
    end else if (mask_r != '0) begin
      bcd_nxt  = {d3, d2, d1, d0};
      prev_nxt = mask_r;
      if (mask_r == mtte_pkg::CHORD_CLEAR) begin
        cursor_nxt      = mtte_pkg::CURSOR_NONE;
        sw_clear_nxt    = 1'b1;
        need_sweep      = 1'b1;
        res_cleared_nxt = 1'b1;
      end else if (mask_r == mtte_pkg::CHORD_MODE) begin
        mode_nxt = ~mode_r;
        li_nxt   = '0;
      end else if (mask_r == mtte_pkg::CHORD_BACK) begin
        if (!cursor_r[5]) begin
          res_written_nxt = 1'b1;
          res_pos_nxt     = cursor_r[AW-1:0];
          res_code_nxt    = mtte_pkg::SPACE_CODE;
          cursor_nxt      = cursor_r - 6'd1;
        end
      end else if (mask_r == mtte_pkg::CHORD_SPACE) begin
        cursor_nxt      = adv_cur;
        need_sweep      = adv_shift;
        res_shifted_nxt = adv_shift;
        res_written_nxt = 1'b1;
        res_pos_nxt     = adv_cur[AW-1:0];
        res_code_nxt    = mtte_pkg::SPACE_CODE;
      end else if (single) begin
        res_written_nxt = 1'b1;
        if (mode_r) begin
          cursor_nxt      = adv_cur;
          need_sweep      = adv_shift;
          res_shifted_nxt = adv_shift;
          res_pos_nxt     = adv_cur[AW-1:0];
          res_code_nxt    = mtte_pkg::DIGIT_ONE + 7'(k);
        end else if (prev_r == mask_r && !cursor_r[5]) begin
          li_nxt       = (li_r >= mtte_pkg::LETTER_LAST) ? 2'd0 : li_r + 2'd1;
          res_pos_nxt  = cursor_r[AW-1:0];
          res_code_nxt = mtte_pkg::letter_code(k, li_nxt);
        end else begin
          li_nxt          = '0;
          cursor_nxt      = adv_cur;
          need_sweep      = adv_shift;
          res_shifted_nxt = adv_shift;
          res_pos_nxt     = adv_cur[AW-1:0];
          res_code_nxt    = mtte_pkg::letter_code(k, 2'd0);
        end
      end
    end
  end

  assign stat.no_result  = !restart_r && (mask_r == '0);
  assign stat.need_sweep = need_sweep;
  assign stat.sweep_last = (sw_cnt_r == mtte_pkg::ADDR_LAST);
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r    <= in_key_mask;
      restart_r <= in_restart;
    end
    if (cmd.exec) begin
      res_cleared_r <= res_cleared_nxt;
      res_shifted_r <= res_shifted_nxt;
      res_written_r <= res_written_nxt;
      res_pos_r     <= res_pos_nxt;
      res_code_r    <= res_code_nxt;
      sw_clear_r    <= sw_clear_nxt;
    end
    if (cmd.publish) begin
      out_press_count_bcd <= bcd_r;
      out_number_mode     <= mode_r;
      out_cursor_pos      <= cursor_r;
      out_buffer_cleared  <= res_cleared_r;
      out_buffer_shifted  <= res_shifted_r;
      out_char_written    <= res_written_r;
      out_char_pos        <= res_written_r ? res_pos_r : '0;
      out_char_code       <= res_written_r ? res_code_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= mtte_pkg::CURSOR_NONE;
      li_r        <= '0;
      prev_r      <= '0;
      mode_r      <= 1'b0;
      bcd_r       <= '0;
      sw_cnt_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mtte_pkg::LINE_LENGTH; i++) begin
        buf_r[i] <= mtte_pkg::SPACE_CODE;
      end
    end else begin
      if (cmd.exec) begin
        cursor_r <= cursor_nxt;
        li_r     <= li_nxt;
        prev_r   <= prev_nxt;
        mode_r   <= mode_nxt;
        bcd_r    <= bcd_nxt;
        sw_cnt_r <= '0;
      end
      if (cmd.sweep) begin
        sw_cnt_r <= sw_cnt_r + 1'b1;
        if (sw_clear_r || sw_cnt_r == mtte_pkg::ADDR_LAST) begin
          buf_r[sw_cnt_r] <= mtte_pkg::SPACE_CODE;
        end else begin
          buf_r[sw_cnt_r] <= buf_r[sw_cnt_r + 1'b1];
        end
      end
      if (cmd.write && res_written_r) begin
        buf_r[res_pos_r] <= res_code_r;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/multi_tap_text_entry_unit.sv =====
// Multi-tap keypad text entry unit, top level.
// Instantiates mtte_ctrl and mtte_dp; uses mtte_pkg.
//
// The input channel takes one item per key event: a 9-bit key mask and a restart
// flag. A nonzero mask or a restart gives exactly one result item on the output
// channel; a zero mask without restart gives none, changes no state and frees the
// input again once it has been decoded.
// An item passes from acceptance to the next acceptance through capture, then decode
// with the update of the cursor, mode and press counter, then the write of the
// character into the line buffer and the publish of the result.
// A clear, a restart or a cursor advance past the last position adds a buffer
// sweep over all 32 entries, one buffer entry per cycle.
// One item is worked on at a time; the next item may be accepted while a finished
// result waits in the output register, and the finished item after it waits in
// the datapath until the receiver takes the earlier one.
// After the synchronous reset the line buffer holds spaces, the cursor is -1,
// the block is in letter mode with a press count of zero and no result is held.
module multi_tap_text_entry_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [8:0]        in_key_mask,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_press_count_bcd,
  output logic              out_number_mode,
  output logic signed [5:0] out_cursor_pos,
  output logic              out_buffer_cleared,
  output logic              out_buffer_shifted,
  output logic              out_char_written,
  output logic [4:0]        out_char_pos,
  output logic [6:0]        out_char_code
);

  mtte_pkg::ctrl_cmd_t cmd;
  mtte_pkg::dp_stat_t  stat;

  mtte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtte_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_key_mask         (in_key_mask),
    .in_restart          (in_restart),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_press_count_bcd (out_press_count_bcd),
    .out_number_mode     (out_number_mode),
    .out_cursor_pos      (out_cursor_pos),
    .out_buffer_cleared  (out_buffer_cleared),
    .out_buffer_shifted  (out_buffer_shifted),
    .out_char_written    (out_char_written),
    .out_char_pos        (out_char_pos),
    .out_char_code       (out_char_code)
  );

endmodule

// ===== verif/multi_tap_text_entry_unit_tb.sv =====
// Self-checking testbench for multi_tap_text_entry_unit: directed key sequences, then random ones.
// A cycle-free model of the keypad line editor predicts every result item.
// Depends on mtte_pkg and the RTL of multi_tap_text_entry_unit only.
module multi_tap_text_entry_unit_tb;

  typedef struct packed {
    logic [15:0] bcd;
    logic        number_mode;
    logic [5:0]  cursor;
    logic        cleared;
    logic        shifted;
    logic        written;
    logic [4:0]  pos;
    logic [6:0]  code;
  } key_result_t;

  localparam int HALF_PERIOD = 6;
  localparam int COUNT_WRAP = 10000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int NO_IDLE_ITEMS = 340;
  localparam bit [8*27-1:0] KEY_LETTERS = ".QZABCDEFGHIJKLMNOPRSTUVWXY";

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [8:0]        in_key_mask = '0;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       out_press_count_bcd;
  logic              out_number_mode;
  logic signed [5:0] out_cursor_pos;
  logic              out_buffer_cleared;
  logic              out_buffer_shifted;
  logic              out_char_written;
  logic [4:0]        out_char_pos;
  logic [6:0]        out_char_code;

  int          typed_pos;
  logic [1:0]  tap_index;
  logic [8:0]  last_mask;
  logic        digit_entry;
  int          press_total;

  key_result_t pending_results[$];
  int          errors = 0;
  int          items_sent = 0;
  int          items_ignored = 0;
  int          results_queued = 0;
  int          results_seen = 0;
  bit          quiet = 1'b0;
  int          hold_cycles = 0;

  multi_tap_text_entry_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_mask         (in_key_mask),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_press_count_bcd (out_press_count_bcd),
    .out_number_mode     (out_number_mode),
    .out_cursor_pos      (out_cursor_pos),
    .out_buffer_cleared  (out_buffer_cleared),
    .out_buffer_shifted  (out_buffer_shifted),
    .out_char_written    (out_char_written),
    .out_char_pos        (out_char_pos),
    .out_char_code       (out_char_code)
  );

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void clear_line_state();
    typed_pos = -1;
    tap_index = '0;
    last_mask = '0;
    digit_entry = 1'b0;
    press_total = 0;
  endfunction

  function automatic bit advance_cursor();
    typed_pos++;
    if (typed_pos >= mtte_pkg::LINE_LENGTH) begin
      typed_pos = mtte_pkg::LINE_LENGTH - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit apply_key_event(input logic [8:0] mask, input logic restart,
                                         output key_result_t r);
    int key;
    r = '0;
    key = -1;
    if (restart) begin
      clear_line_state();
      r.cleared = 1'b1;
    end else if (mask == '0) begin
      return 1'b0;
    end else begin
      press_total = (press_total + 1) % COUNT_WRAP;
      for (int n = 0; n < mtte_pkg::KEY_COUNT; n++)
        if (mask == 9'(1 << n)) key = n;
      if (mask == mtte_pkg::CHORD_CLEAR) begin
        typed_pos = -1;
        r.cleared = 1'b1;
      end else if (mask == mtte_pkg::CHORD_MODE) begin
        digit_entry = ~digit_entry;
        tap_index = '0;
      end else if (mask == mtte_pkg::CHORD_BACK) begin
        if (typed_pos >= 0) begin
          r.written = 1'b1;
          r.pos = 5'(typed_pos);
          r.code = mtte_pkg::SPACE_CODE;
          typed_pos--;
        end
      end else if (mask == mtte_pkg::CHORD_SPACE) begin
        r.shifted = advance_cursor();
        r.written = 1'b1;
        r.pos = 5'(typed_pos);
        r.code = mtte_pkg::SPACE_CODE;
      end else if (key >= 0) begin
        if (digit_entry) begin
          r.shifted = advance_cursor();
          r.code = mtte_pkg::DIGIT_ONE + 7'(key);
        end else begin
          if (last_mask == mask && typed_pos >= 0) begin
            tap_index = 2'((tap_index + 1) % mtte_pkg::LETTERS_PER_KEY);
          end else begin
            r.shifted = advance_cursor();
            tap_index = '0;
          end
          r.code = KEY_LETTERS[8*(26 - (key*3 + tap_index)) +: 7];
        end
        r.written = 1'b1;
        r.pos = 5'(typed_pos);
      end
      last_mask = mask;
    end
    r.bcd = {4'(press_total / 1000 % 10), 4'(press_total / 100 % 10),
             4'(press_total / 10 % 10), 4'(press_total % 10)};
    r.number_mode = digit_entry;
    r.cursor = 6'(typed_pos);
    return 1'b1;
  endfunction

  task automatic send_key(input logic [8:0] mask, input logic restart);
    key_result_t r;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_key_mask = mask;
    in_restart = restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (apply_key_event(mask, restart, r)) begin
      pending_results.push_back(r);
      results_queued++;
    end else begin
      items_ignored++;
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [8:0] any_single_key();
    return 9'(1 << $urandom_range(mtte_pkg::KEY_COUNT - 1));
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = quiet || ($urandom_range(99) >= 10);
    end
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, actual count %h cursor %h",
                 $time, out_press_count_bcd, out_cursor_pos);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("press_count_bcd", want.bcd, out_press_count_bcd);
        check_field("number_mode", want.number_mode, out_number_mode);
        check_field("cursor_pos", want.cursor, $unsigned(out_cursor_pos));
        check_field("buffer_cleared", want.cleared, out_buffer_cleared);
        check_field("buffer_shifted", want.shifted, out_buffer_shifted);
        check_field("char_written", want.written, out_char_written);
        check_field("char_pos", want.pos, out_char_pos);
        check_field("char_code", want.code, out_char_code);
      end
    end
  end

  // Repeated presses of one key step through its letters and wrap back to the first.
  task automatic test_letter_cycling();
    repeat (4) send_key(9'h002, 1'b0);
    send_key(9'h001, 1'b0);
    send_key(9'h100, 1'b0);
    send_key(9'h100, 1'b0);
  endtask

  task automatic test_chords();
    repeat (4) send_key(mtte_pkg::CHORD_BACK, 1'b0);
    send_key(mtte_pkg::CHORD_MODE, 1'b0);
    send_key(9'h001, 1'b0);
    send_key(9'h100, 1'b0);
    send_key(mtte_pkg::CHORD_MODE, 1'b0);
    send_key(mtte_pkg::CHORD_SPACE, 1'b0);
    send_key(9'h1FF, 1'b0);
    send_key(9'h003, 1'b0);
    send_key(mtte_pkg::CHORD_CLEAR, 1'b0);
    send_key(9'h000, 1'b0);
  endtask

  task automatic test_restart();
    send_key(9'h1FF, 1'b1);
    send_key(9'h000, 1'b1);
    send_key(9'h004, 1'b0);
    send_key(9'h004, 1'b0);
  endtask

  task automatic test_line_overflow();
    if (!digit_entry) send_key(mtte_pkg::CHORD_MODE, 1'b0);
    repeat (mtte_pkg::LINE_LENGTH + 4) send_key(any_single_key(), 1'b0);
    send_key(mtte_pkg::CHORD_SPACE, 1'b0);
    send_key(mtte_pkg::CHORD_MODE, 1'b0);
    repeat (mtte_pkg::LINE_LENGTH + 2) send_key(any_single_key(), 1'b0);
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    hold_cycles = 200;
    repeat (16) send_key(any_single_key(), 1'b0);
    wait_for_results();
  endtask

  // Sends a long run of presses with no idle cycles on either side.
  task automatic test_no_idle_run();
    int pick;
    logic [8:0] key;
    key = 9'h008;
    quiet = 1'b1;
    repeat (NO_IDLE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_key(key, 1'b0);
      end else if (pick < 65) begin
        send_key(mtte_pkg::CHORD_MODE, 1'b0);
      end else if (pick < 85) begin
        send_key(mtte_pkg::CHORD_BACK, 1'b0);
      end else begin
        key = any_single_key();
        send_key(key, 1'b0);
      end
    end
    wait_for_results();
    quiet = 1'b0;
  endtask

  task automatic test_random_entry();
    int target;
    int pick;
    logic [8:0] key;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        key = any_single_key();
        repeat ($urandom_range(4, 1)) send_key(key, 1'b0);
      end else if (pick < 55) begin
        if (!digit_entry) send_key(mtte_pkg::CHORD_MODE, 1'b0);
        repeat ($urandom_range(6, 1)) send_key(any_single_key(), 1'b0);
        if ($urandom_range(1)) send_key(mtte_pkg::CHORD_MODE, 1'b0);
      end else if (pick < 70) begin
        case ($urandom_range(9))
          0:       send_key(mtte_pkg::CHORD_CLEAR, 1'b0);
          1, 2:    send_key(mtte_pkg::CHORD_MODE, 1'b0);
          3, 4, 5: send_key(mtte_pkg::CHORD_BACK, 1'b0);
          default: send_key(mtte_pkg::CHORD_SPACE, 1'b0);
        endcase
      end else if (pick < 80) begin
        repeat ($urandom_range(5, 1)) send_key(mtte_pkg::CHORD_BACK, 1'b0);
      end else if (pick < 92) begin
        send_key(9'($urandom_range(511)), 1'b0);
      end else if (pick < 94) begin
        send_key(9'($urandom_range(511)), 1'b1);
      end else begin
        send_key(9'h000, 1'b0);
      end
    end
  endtask

  initial begin
    clear_line_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_letter_cycling();
    test_chords();
    test_restart();
    test_line_overflow();
    test_backpressure();
    test_no_idle_run();
    test_random_entry();
    wait_for_results();
    repeat (60) @(posedge clk);
    $display("Sent %0d items (%0d without a result), checked %0d results.",
             items_sent, items_ignored, results_seen);
    $display("Covered multi-tap cycling, digit entry, all chords, line overflow, restart,");
    $display("a long run without idle cycles, long output stalls and random key masks.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
